// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the DNS response scanner.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/dnsrs_pkg.sv -----
// ----------------------------------------------------------------------------
// dnsrs_pkg
// Types and constants shared by the DNS response scanner modules.
// ----------------------------------------------------------------------------
package dnsrs_pkg;

   localparam int MAX_MESSAGE_BYTES = 8192;
   localparam int LEN_W   = 14;
   localparam int OFS_W   = $clog2(MAX_MESSAGE_BYTES);
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TTL      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CACHE_ENABLE = 2'd1;

   localparam logic [31:0] MAX_TTL_RESET = 32'd86400;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MESSAGE_BYTES);

   localparam logic [7:0] PTR_MARK    = 8'hc0;
   localparam logic [7:0] MAX_LABEL   = 8'd63;
   localparam logic [15:0] CLASS_IN   = 16'h0001;
   localparam logic [15:0] TYPE_A     = 16'h0001;
   localparam logic [12:0] NAME_SAT   = 13'd8191;

   typedef enum logic [3:0] {
      PH_HEADER, PH_QLEN, PH_QLABEL, PH_QTAIL, PH_ANAME, PH_ALEN,
      PH_ALABEL, PH_APTR, PH_RR, PH_RDATA, PH_END
   } phase_type;

   // One byte handed from the front end to the parser
   typedef struct packed {
      logic [7:0]       msg_byte;
      logic [OFS_W-1:0] offset;
      logic [LEN_W-1:0] size;
      logic             scan;
      logic             is_last;
   } scan_item_type;

endpackage

// ----- src/dnsrs_front.sv -----
// ----------------------------------------------------------------------------
// dnsrs_front
// Accepts message bytes, tracks offset and message size, tags each byte.
// ----------------------------------------------------------------------------
module dnsrs_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_msg_byte,
   input  logic [dnsrs_pkg::LEN_W-1:0] req_msg_length,
   input  logic                    req_is_last,
   output logic                    push,
   output dnsrs_pkg::scan_item_type push_item,
   input  logic                    queue_full
);
   import dnsrs_pkg::*;

   logic             started_ff, started_in;
   logic [LEN_W-1:0] offset_ff, offset_in;
   logic [LEN_W-1:0] size_ff, size_in;
   logic [LEN_W-1:0] cur_size, cur_ofs, capped;
   logic             scan;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign capped    = (req_msg_length > MAX_LEN) ? MAX_LEN : req_msg_length;
   assign cur_size  = started_ff ? size_ff : capped;
   assign cur_ofs   = started_ff ? offset_ff : '0;
   assign scan      = cur_ofs < cur_size;

   always_comb begin
      push_item.msg_byte = req_msg_byte;
      push_item.offset   = cur_ofs[OFS_W-1:0];
      push_item.size     = cur_size;
      push_item.scan     = scan;
      push_item.is_last  = req_is_last;
      started_in = started_ff;
      offset_in  = offset_ff;
      size_in    = size_ff;
      if (push) begin
         started_in = !req_is_last;
         size_in    = cur_size;
         offset_in  = scan ? cur_ofs + LEN_W'(1) : cur_ofs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         offset_ff  <= '0;
         size_ff    <= '0;
      end else begin
         started_ff <= started_in;
         offset_ff  <= offset_in;
         size_ff    <= size_in;
      end
   end

endmodule

// ----- src/dnsrs_queue.sv -----
// ----------------------------------------------------------------------------
// dnsrs_queue
// Two-entry queue between the front end and the parser.
// ----------------------------------------------------------------------------
module dnsrs_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  dnsrs_pkg::scan_item_type push_item,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output dnsrs_pkg::scan_item_type head_item
);
   import dnsrs_pkg::*;

   scan_item_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/dnsrs_back.sv -----
// ----------------------------------------------------------------------------
// dnsrs_back
// Parses header, question and answers one byte a cycle unless rsp stalls; registers results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dnsrs_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  dnsrs_pkg::scan_item_type head_item,
   output logic                     pop,
   input  logic [31:0]              max_ttl,
   input  logic                     cache_enable,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_kind,
   output logic [7:0]               rsp_domain_char,
   output logic                     rsp_cacheable,
   output logic                     rsp_well_formed,
   output logic [31:0]              rsp_min_ttl,
   output logic [15:0]              rsp_answer_total,
   output logic [dnsrs_pkg::LEN_W-1:0] rsp_answer_bytes,
   output logic [dnsrs_pkg::LEN_W-1:0] rsp_forward_length,
   output logic [12:0]              rsp_domain_length
);
   import dnsrs_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [7:0]       label_ff, label_in;
   logic [3:0]       fidx_ff, fidx_in;
   logic [31:0]      acc_ff, acc_in;
   logic             flags_ff, flags_in;
   logic [15:0]      expected_ff, expected_in;
   logic [15:0]      seen_ff, seen_in;
   logic [31:0]      min_ff, min_in;
   logic [15:0]      rdrem_ff, rdrem_in;
   logic [LEN_W-1:0] astart_ff, astart_in;
   logic [LEN_W-1:0] aend_ff, aend_in;
   logic [12:0]      nlen_ff, nlen_in;
   logic             fault_ff, fault_in;

   logic             out_valid_ff, out_valid_in;
   logic             kind_ff, kind_in;
   logic [7:0]       char_ff, char_in;
   logic             cache_ff, cache_in;
   logic             wf_ff, wf_in;
   logic [31:0]      ttl_ff, ttl_in;
   logic [15:0]      total_ff, total_in;
   logic [LEN_W-1:0] abytes_ff, abytes_in;
   logic [LEN_W-1:0] fwd_ff, fwd_in;
   logic [12:0]      dlen_ff, dlen_in;

   logic             emit, ok;
   logic [7:0]       ch, b;
   logic [17:0]      p_ext, sz_ext, nxt;
   logic [LEN_W-1:0] p_one;

   assign pop = head_valid && (!out_valid_ff || rsp_ready);
   assign b      = head_item.msg_byte;
   assign p_ext  = 18'(head_item.offset);
   assign sz_ext = 18'(head_item.size);
   assign p_one  = LEN_W'(head_item.offset) + LEN_W'(1);

   always_comb begin
      phase_in = phase_ff;  label_in = label_ff;  fidx_in = fidx_ff;
      acc_in = acc_ff;  flags_in = flags_ff;  expected_in = expected_ff;
      seen_in = seen_ff;  min_in = min_ff;  rdrem_in = rdrem_ff;
      astart_in = astart_ff;  aend_in = aend_ff;  nlen_in = nlen_ff;
      fault_in = fault_ff;
      emit = 1'b0;
      ch   = 8'd0;
      nxt  = 18'd0;
      if (pop && head_item.scan) begin
         case (phase_ff)
            PH_HEADER: begin
               if (p_ext == 18'd2) begin
                  flags_in = b[7] && !b[1];
               end else if (p_ext == 18'd4) begin
                  acc_in = {24'd0, b};
               end else if (p_ext == 18'd5) begin
                  if ({acc_ff[7:0], b} != 16'd1) flags_in = 1'b0;
               end else if (p_ext == 18'd6) begin
                  expected_in = {b, 8'd0};
               end else if (p_ext == 18'd7) begin
                  expected_in = {expected_ff[15:8], b};
               end else if (p_ext == 18'd11) begin
                  if (flags_ff && expected_ff != 16'd0) phase_in = PH_QLEN;
                  else begin fault_in = 1'b1; phase_in = PH_END; end
               end
            end
            PH_QLEN: begin
               if (b > MAX_LABEL || p_ext + 18'(b) + 18'd5 > sz_ext) begin
                  fault_in = 1'b1;
                  phase_in = PH_END;
               end else if (b != 8'd0) begin
                  if (nlen_ff != 13'd0) begin
                     emit = 1'b1;
                     ch   = 8'h2e;
                     if (nlen_ff < NAME_SAT) nlen_in = nlen_ff + 13'd1;
                  end
                  label_in = b;
                  phase_in = PH_QLABEL;
               end else begin
                  fidx_in  = 4'd0;
                  acc_in   = 32'd0;
                  phase_in = PH_QTAIL;
               end
            end
            PH_QLABEL: begin
               emit = 1'b1;
               ch   = (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
               if (nlen_ff < NAME_SAT) nlen_in = nlen_ff + 13'd1;
               label_in = label_ff - 8'd1;
               if (label_in == 8'd0) phase_in = PH_QLEN;
            end
            PH_QTAIL: begin
               acc_in = {acc_ff[23:0], b};
               if (fidx_ff == 4'd3) begin
                  if (acc_in[15:0] != CLASS_IN || acc_in[31:16] != TYPE_A) begin
                     fault_in = 1'b1;
                     phase_in = PH_END;
                  end else begin
                     astart_in = p_one;
                     min_in    = max_ttl;
                     seen_in   = 16'd0;
                     if (p_ext + 18'd1 >= sz_ext) begin
                        aend_in  = p_one;
                        phase_in = PH_END;
                     end else begin
                        phase_in = PH_ANAME;
                     end
                  end
               end
               fidx_in = fidx_ff + 4'd1;
            end
            PH_ANAME, PH_ALEN: begin
               if (phase_ff == PH_ANAME && b == PTR_MARK) begin
                  if (p_ext + 18'd12 > sz_ext) begin
                     fault_in = 1'b1;
                     phase_in = PH_END;
                  end else begin
                     phase_in = PH_APTR;
                  end
               end else if (b > MAX_LABEL || p_ext + 18'(b) + 18'd11 > sz_ext) begin
                  fault_in = 1'b1;
                  phase_in = PH_END;
               end else if (b != 8'd0) begin
                  label_in = b;
                  phase_in = PH_ALABEL;
               end else begin
                  fidx_in  = 4'd0;
                  phase_in = PH_RR;
               end
            end
            PH_ALABEL: begin
               label_in = label_ff - 8'd1;
               if (label_in == 8'd0) phase_in = PH_ALEN;
            end
            PH_APTR: begin
               fidx_in  = 4'd0;
               phase_in = PH_RR;
            end
            PH_RR: begin
               acc_in = {acc_ff[23:0], b};
               if (fidx_ff == 4'd3) begin
                  if (acc_in[15:0] != CLASS_IN) begin
                     fault_in = 1'b1;
                     phase_in = PH_END;
                  end else begin
                     fidx_in = fidx_ff + 4'd1;
                  end
               end else if (fidx_ff == 4'd9) begin
                  nxt = p_ext + 18'd1 + 18'(acc_in[15:0]);
                  if (nxt > sz_ext) begin
                     fault_in = 1'b1;
                     phase_in = PH_END;
                  end else if (acc_in[15:0] == 16'd0) begin
                     seen_in = seen_ff + 16'd1;
                     if (seen_in >= expected_ff || nxt >= sz_ext) begin
                        aend_in  = nxt[LEN_W-1:0];
                        phase_in = PH_END;
                     end else begin
                        phase_in = PH_ANAME;
                     end
                  end else begin
                     rdrem_in = acc_in[15:0];
                     phase_in = PH_RDATA;
                  end
               end else begin
                  if (fidx_ff == 4'd7 && acc_in < min_ff) min_in = acc_in;
                  fidx_in = fidx_ff + 4'd1;
               end
            end
            PH_RDATA: begin
               rdrem_in = rdrem_ff - 16'd1;
               if (rdrem_in == 16'd0) begin
                  seen_in = seen_ff + 16'd1;
                  if (seen_in >= expected_ff || p_ext + 18'd1 >= sz_ext) begin
                     aend_in  = p_one;
                     phase_in = PH_END;
                  end else begin
                     phase_in = PH_ANAME;
                  end
               end
            end
            default: ;
         endcase
      end

      ok = phase_in == PH_END && !fault_in;
      out_valid_in = out_valid_ff && !rsp_ready;
      kind_in = kind_ff;  char_in = char_ff;  cache_in = cache_ff;  wf_in = wf_ff;
      ttl_in = ttl_ff;  total_in = total_ff;  abytes_in = abytes_ff;
      fwd_in = fwd_ff;  dlen_in = dlen_ff;
      if (pop && head_item.is_last) begin
         out_valid_in = 1'b1;
         kind_in   = 1'b1;
         char_in   = 8'd0;
         cache_in  = ok && cache_enable;
         wf_in     = ok;
         ttl_in    = min_in;
         total_in  = expected_in;
         abytes_in = ok ? aend_in - astart_in : '0;
         fwd_in    = ok ? aend_in : head_item.size;
         dlen_in   = nlen_in;
         // start the next message from a clean slate
         phase_in = PH_HEADER;  label_in = 8'd0;  fidx_in = 4'd0;  acc_in = 32'd0;
         flags_in = 1'b0;  expected_in = 16'd0;  seen_in = 16'd0;  min_in = max_ttl;
         rdrem_in = 16'd0;  astart_in = '0;  aend_in = '0;  nlen_in = 13'd0;
         fault_in = 1'b0;
      end else if (pop && emit) begin
         out_valid_in = 1'b1;
         kind_in   = 1'b0;
         char_in   = ch;
         cache_in  = 1'b0;
         wf_in     = 1'b0;
         ttl_in    = 32'd0;
         total_in  = 16'd0;
         abytes_in = '0;
         fwd_in    = '0;
         dlen_in   = 13'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;  label_ff <= '0;  fidx_ff <= '0;  acc_ff <= '0;
         flags_ff <= 1'b0;  expected_ff <= '0;  seen_ff <= '0;
         min_ff <= MAX_TTL_RESET;  rdrem_ff <= '0;  astart_ff <= '0;  aend_ff <= '0;
         nlen_ff <= '0;  fault_ff <= 1'b0;  out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;  label_ff <= label_in;  fidx_ff <= fidx_in;
         acc_ff <= acc_in;  flags_ff <= flags_in;  expected_ff <= expected_in;
         seen_ff <= seen_in;  min_ff <= min_in;  rdrem_ff <= rdrem_in;
         astart_ff <= astart_in;  aend_ff <= aend_in;  nlen_ff <= nlen_in;
         fault_ff <= fault_in;  out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;  char_ff <= char_in;  cache_ff <= cache_in;  wf_ff <= wf_in;
      ttl_ff <= ttl_in;  total_ff <= total_in;  abytes_ff <= abytes_in;
      fwd_ff <= fwd_in;  dlen_ff <= dlen_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_domain_char    = char_ff;
   assign rsp_cacheable      = cache_ff;
   assign rsp_well_formed    = wf_ff;
   assign rsp_min_ttl        = ttl_ff;
   assign rsp_answer_total   = total_ff;
   assign rsp_answer_bytes   = abytes_ff;
   assign rsp_forward_length = fwd_ff;
   assign rsp_domain_length  = dlen_ff;

   `ASSERT_ALWAYS(a_fault_ends, clock, reset, !fault_ff || phase_ff == PH_END,
      "fault outside end phase")
   `ASSERT_NEXT(a_last_clears, clock, reset, pop && head_item.is_last,
      phase_ff == PH_HEADER && !fault_ff && nlen_ff == 13'd0,
      "state not cleared after last byte")
   `ASSERT_ALWAYS(a_char_quiet, clock, reset, !(out_valid_ff && !kind_ff) ||
      (!cache_ff && !wf_ff && fwd_ff == '0 && dlen_ff == 13'd0),
      "summary fields set on a character")
   `ASSERT_ALWAYS(a_cache_ok, clock, reset, !(out_valid_ff && cache_ff) || wf_ff,
      "cacheable without well formed")

endmodule

// ----- src/dns_response_scan.sv -----
// ----------------------------------------------------------------------------
// dns_response_scan
// Streaming DNS response checker: question name out, per-message summary.
// ----------------------------------------------------------------------------
// channel  direction  payload
// req      in         msg_byte, msg_length, is_last (one message byte)
// rsp      out        kind, domain_char or end-of-message summary fields
// csr      in         index, data (0: max_ttl, 1: cache_enable)
//
// One byte per cycle sustained while rsp is not stalled; the front end tags each
// byte as it is accepted into a two-entry queue, and the back end parses the queue
// head and loads any result into the output register at the edge that pops it.
// A byte passes through a queue slot, and its result through the output register.
// Synchronous active-high reset; no clearing pass is needed.
// A stalled rsp channel holds the parser, then fills the queue, then drops req_ready.
// ----------------------------------------------------------------------------
module dns_response_scan (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_msg_byte,
   input  logic [dnsrs_pkg::LEN_W-1:0] req_msg_length,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_domain_char,
   output logic        rsp_cacheable,
   output logic        rsp_well_formed,
   output logic [31:0] rsp_min_ttl,
   output logic [15:0] rsp_answer_total,
   output logic [dnsrs_pkg::LEN_W-1:0] rsp_answer_bytes,
   output logic [dnsrs_pkg::LEN_W-1:0] rsp_forward_length,
   output logic [12:0] rsp_domain_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [dnsrs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import dnsrs_pkg::*;

   logic [31:0]   max_ttl_ff;
   logic          cache_en_ff;
   logic          push, full, pop, head_valid;
   scan_item_type push_item, head_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ttl_ff  <= MAX_TTL_RESET;
         cache_en_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_TTL:      max_ttl_ff  <= csr_data;
            CSR_CACHE_ENABLE: cache_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   dnsrs_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_msg_byte, .req_msg_length,
      .req_is_last, .push, .push_item, .queue_full(full)
   );

   dnsrs_queue u_queue (
      .clock, .reset, .push, .push_item, .full, .pop, .head_valid, .head_item
   );

   dnsrs_back u_back (
      .clock, .reset, .head_valid, .head_item, .pop,
      .max_ttl(max_ttl_ff), .cache_enable(cache_en_ff),
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_domain_char, .rsp_cacheable,
      .rsp_well_formed, .rsp_min_ttl, .rsp_answer_total, .rsp_answer_bytes,
      .rsp_forward_length, .rsp_domain_length
   );

endmodule
